>>> hw/rtl/wlqe_pkg.sv
// ----------------------------------------------------------------------------
// wlqe_pkg: shared constants and types for the wide line quad expander
// Fixed field widths, rounding constants and the per-vertex selection table.
// ----------------------------------------------------------------------------
`default_nettype none

package wlqe_pkg;

  // Bits of each half-width offset magnitude found by the cell chain.
  localparam int RBITS      = 25;
  localparam int WIDTH_BITS = 12;
  localparam int COLOR_BITS = 32;
  localparam int VERT_BITS  = 24;
  localparam int CNT_BITS   = 4;

  // Zero-length segment: offset is (w/2) in output fixed point, rounded.
  localparam int ZERO_ROUND = 16;
  localparam int ZERO_SHIFT = 5;

  localparam logic [COLOR_BITS-1:0] ALPHA_CLEAR = 32'hFFFF_FF00;

  localparam logic [CNT_BITS-1:0] VTX_STRIP_LAST   = 4'd5;
  localparam logic [CNT_BITS-1:0] VTX_OUTLINE_LAST = 4'd9;

  typedef enum logic [2:0] {
    OFS_MINUS = 3'b001,
    OFS_NONE  = 3'b010,
    OFS_PLUS  = 3'b100
  } ofs_t;

  typedef enum logic [2:0] {
    COL_START = 3'b001,
    COL_END   = 3'b010,
    COL_LINE  = 3'b100
  } col_t;

  typedef struct packed {
    logic use_end;
    ofs_t ofs;
    col_t col;
    logic fade;
    logic outline;
  } vsel_t;

  // Strip: S-o, E-o, S, E, S+o, E+o. Outline loop: S-o, E-o, E+o, S+o.
  function automatic vsel_t vertex_sel(input logic [CNT_BITS-1:0] k);
    vsel_t s;
    case (k)
      4'd0:    s = '{1'b0, OFS_MINUS, COL_START, 1'b1, 1'b0};
      4'd1:    s = '{1'b1, OFS_MINUS, COL_END,   1'b1, 1'b0};
      4'd2:    s = '{1'b0, OFS_NONE,  COL_START, 1'b0, 1'b0};
      4'd3:    s = '{1'b1, OFS_NONE,  COL_END,   1'b0, 1'b0};
      4'd4:    s = '{1'b0, OFS_PLUS,  COL_START, 1'b1, 1'b0};
      4'd5:    s = '{1'b1, OFS_PLUS,  COL_END,   1'b1, 1'b0};
      4'd6:    s = '{1'b0, OFS_MINUS, COL_LINE,  1'b0, 1'b1};
      4'd7:    s = '{1'b1, OFS_MINUS, COL_LINE,  1'b0, 1'b1};
      4'd8:    s = '{1'b1, OFS_PLUS,  COL_LINE,  1'b0, 1'b1};
      4'd9:    s = '{1'b0, OFS_PLUS,  COL_LINE,  1'b0, 1'b1};
      default: s = '{1'b0, OFS_MINUS, COL_START, 1'b1, 1'b0};
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/wide_line_quad_expander_top.sv
// ----------------------------------------------------------------------------
// wide_line_quad_expander_top: wide line to feathered quad expansion
// Turns one line segment into a six-vertex feathered strip and, when asked,
// a four-vertex outline loop, with a rounded perpendicular half-width offset.
// ----------------------------------------------------------------------------
//
//   Channel | Handshake            | Payload
//   --------+----------------------+---------------------------------------
//   in      | in_valid / in_stall  | start_x..end_y, line_width, colors,
//           |                      | outline_enable (one request = segment)
//   out     | out_valid / out_stall| vert_x, vert_y, color_rgba, is_outline,
//           |                      | last_vertex (one request = vertex)
//
// The output sends one vertex a cycle unless stalled, six per segment, or ten
// when the outline is enabled; that port sets the rate.
// A request passes through three setup stages, one cell for each of the 25
// offset bits, the vertex holding slot and the output register, the first
// of them loaded at the accepting edge. Up to 28 segments are in flight
// behind the one being sent.
// Reset is synchronous and clears only the valid flags and the vertex count.
// A stall on the output backs up through the chain; a stage moves whenever
// the stage after it is empty or moving, so bubbles are squeezed out.
//
// The offset magnitude r is the largest value with
//   (2r-1)^2 * len^2 <= (w * |d|)^2 * 2^(2*FRAC_BITS-8),
// which is the rounded value of (w/2) * |d| / len in output fixed point.
// Each cell tests one bit of r from the top down by a shifted trial subtract
// on a running residual, carrying (2r-1)*len^2 along so that no cell needs
// a multiplier.
`default_nettype none

module wide_line_quad_expander_top import wlqe_pkg::*; #(
  parameter int COORD_BITS = 15,
  parameter int FRAC_BITS  = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  input  logic [WIDTH_BITS-1:0]       line_width,
  input  logic [COLOR_BITS-1:0]       start_color,
  input  logic [COLOR_BITS-1:0]       end_color,
  input  logic [COLOR_BITS-1:0]       outline_color,
  input  logic                        outline_enable,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [VERT_BITS-1:0] vert_x,
  output logic signed [VERT_BITS-1:0] vert_y,
  output logic [COLOR_BITS-1:0]       color_rgba,
  output logic                        is_outline,
  output logic                        last_vertex
);

  localparam int C   = COORD_BITS;
  localparam int LW  = 2 * C + 1;
  localparam int W   = 2 * C + 56;
  localparam int PW  = 2 * C + 29;
  localparam int SWI = 4 * C + WIDTH_BITS + 3 * COLOR_BITS + 1;
  localparam int SW  = SWI + 3;
  localparam int ZW  = WIDTH_BITS + FRAC_BITS + 1;

  logic                 in_ready, emit_ready;
  logic [SWI-1:0]       side_in;

  // Stage 0 of the chain is the setup output; stage i+1 follows cell i.
  logic                 ch_valid [RBITS+1];
  logic                 ch_ready [RBITS+1];
  logic signed [W-1:0]  ch_res_x [RBITS+1];
  logic signed [W-1:0]  ch_res_y [RBITS+1];
  logic signed [PW-1:0] ch_p_x   [RBITS+1];
  logic signed [PW-1:0] ch_p_y   [RBITS+1];
  logic [RBITS-1:0]     ch_r_x   [RBITS+1];
  logic [RBITS-1:0]     ch_r_y   [RBITS+1];
  logic [LW-1:0]        ch_lsq   [RBITS+1];
  logic [SW-1:0]        ch_side  [RBITS+1];
  logic signed [PW-1:0] prep_p;

  logic                 f_zero, f_dyneg, f_dxneg, f_stroke;
  logic signed [C-1:0]  f_sx, f_sy, f_ex, f_ey;
  logic [WIDTH_BITS-1:0] f_w;
  logic [COLOR_BITS-1:0] f_c1, f_c2, f_cs;
  logic signed [RBITS:0] mag_x, mag_y, wx_fin, wy_fin, zero_wy;
  logic [ZW-1:0]        zsum;

  assign in_stall = !in_ready;
  assign side_in  = {start_x, start_y, end_x, end_y, line_width,
                     start_color, end_color, outline_color, outline_enable};

  wlqe_prep #(.C(C), .F(FRAC_BITS), .SWI(SWI), .W(W), .PW(PW), .LW(LW)) u_prep (
    .clk      (clk),
    .rst      (rst),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .sx       (start_x),
    .sy       (start_y),
    .ex       (end_x),
    .ey       (end_y),
    .w        (line_width),
    .side_in  (side_in),
    .dn_valid (ch_valid[0]),
    .dn_ready (ch_ready[0]),
    .dn_res_x (ch_res_x[0]),
    .dn_res_y (ch_res_y[0]),
    .dn_p     (prep_p),
    .dn_lsq   (ch_lsq[0]),
    .dn_side  (ch_side[0])
  );

  assign ch_p_x[0] = prep_p;
  assign ch_p_y[0] = prep_p;
  assign ch_r_x[0] = '0;
  assign ch_r_y[0] = '0;

  for (genvar i = 0; i < RBITS; i++) begin : g_cell
    wlqe_cell #(.W(W), .PW(PW), .LW(LW), .SW(SW), .BIT(RBITS - 1 - i)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (ch_valid[i]),
      .up_ready (ch_ready[i]),
      .up_res_x (ch_res_x[i]),
      .up_res_y (ch_res_y[i]),
      .up_p_x   (ch_p_x[i]),
      .up_p_y   (ch_p_y[i]),
      .up_r_x   (ch_r_x[i]),
      .up_r_y   (ch_r_y[i]),
      .up_lsq   (ch_lsq[i]),
      .up_side  (ch_side[i]),
      .dn_valid (ch_valid[i+1]),
      .dn_ready (ch_ready[i+1]),
      .dn_res_x (ch_res_x[i+1]),
      .dn_res_y (ch_res_y[i+1]),
      .dn_p_x   (ch_p_x[i+1]),
      .dn_p_y   (ch_p_y[i+1]),
      .dn_r_x   (ch_r_x[i+1]),
      .dn_r_y   (ch_r_y[i+1]),
      .dn_lsq   (ch_lsq[i+1]),
      .dn_side  (ch_side[i+1])
    );
  end

  assign ch_ready[RBITS] = emit_ready;

  assign {f_zero, f_dyneg, f_dxneg, f_sx, f_sy, f_ex, f_ey, f_w,
          f_c1, f_c2, f_cs, f_stroke} = ch_side[RBITS];

  // The x offset follows dy and the y offset follows dx. A zero-length
  // segment takes the direction as angle zero: no x offset, y offset w/2.
  assign zsum    = (ZW'(f_w) << FRAC_BITS) + ZW'(ZERO_ROUND);
  assign zero_wy = $signed((RBITS+1)'(zsum >> ZERO_SHIFT));
  assign mag_x   = $signed({1'b0, ch_r_x[RBITS]});
  assign mag_y   = $signed({1'b0, ch_r_y[RBITS]});
  assign wx_fin  = f_zero ? '0 : (f_dyneg ? -mag_x : mag_x);
  assign wy_fin  = f_zero ? zero_wy : (f_dxneg ? -mag_y : mag_y);

  wlqe_emit #(.C(C), .F(FRAC_BITS)) u_emit (
    .clk         (clk),
    .rst         (rst),
    .up_valid    (ch_valid[RBITS]),
    .up_ready    (emit_ready),
    .sx          (f_sx),
    .sy          (f_sy),
    .ex          (f_ex),
    .ey          (f_ey),
    .wx          (wx_fin),
    .wy          (wy_fin),
    .c1          (f_c1),
    .c2          (f_c2),
    .cs          (f_cs),
    .stroke      (f_stroke),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .vert_x      (vert_x),
    .vert_y      (vert_y),
    .color_rgba  (color_rgba),
    .is_outline  (is_outline),
    .last_vertex (last_vertex)
  );

`ifndef SYNTH
  // Within a segment the vertices follow one another with no gap.
  a_burst: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_vertex |=> out_valid)
    else $error("vertex burst broken before the last vertex");

  // The final strip vertex is an outer one, so its alpha is cleared.
  a_fade: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_vertex && !is_outline |-> color_rgba[7:0] == 8'd0)
    else $error("last strip vertex carries nonzero alpha");

  // An outline loop is never cut short by a strip vertex.
  a_loop: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_outline && !last_vertex && !out_stall |=> is_outline)
    else $error("outline loop interrupted");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/wlqe_prep.sv
// ----------------------------------------------------------------------------
// wlqe_prep: segment setup pipeline
// Three stages: deltas and magnitudes, squared length and width products,
// then the starting residuals for the offset cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

module wlqe_prep import wlqe_pkg::*; #(
  parameter int C    = 15,
  parameter int F    = 8,
  parameter int SWI  = 169,
  parameter int W    = 86,
  parameter int PW   = 59,
  parameter int LW   = 31
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  logic signed [C-1:0]  sx,
  input  logic signed [C-1:0]  sy,
  input  logic signed [C-1:0]  ex,
  input  logic signed [C-1:0]  ey,
  input  logic [WIDTH_BITS-1:0] w,
  input  logic [SWI-1:0]       side_in,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output logic signed [W-1:0]  dn_res_x,
  output logic signed [W-1:0]  dn_res_y,
  output logic signed [PW-1:0] dn_p,
  output logic [LW-1:0]        dn_lsq,
  output logic [SWI+2:0]       dn_side
);

  localparam int MW = WIDTH_BITS + C;
  localparam int SH = 2 * F - 8;

  logic signed [C:0] dx, dy;
  logic [C-1:0]      adx_c, ady_c;

  logic              s1_valid, s2_valid;
  logic [C-1:0]      s1_adx, s1_ady;
  logic [WIDTH_BITS-1:0] s1_w;
  logic [SWI+1:0]    s1_side;
  logic [LW-1:0]     s2_lsq;
  logic [MW-1:0]     s2_mx, s2_my;
  logic [SWI+1:0]    s2_side;

  logic [2*C-1:0]    sqx, sqy;
  logic [MW-1:0]     mx_c, my_c;
  logic [2*MW-1:0]   tsq_x, tsq_y;
  logic [W-1:0]      tx, ty;
  logic              rdy1, rdy2, rdy3;

  assign rdy3     = !dn_valid || dn_ready;
  assign rdy2     = !s2_valid || rdy3;
  assign rdy1     = !s1_valid || rdy2;
  assign up_ready = rdy1;

  assign dx    = (C+1)'(ex) - (C+1)'(sx);
  assign dy    = (C+1)'(ey) - (C+1)'(sy);
  assign adx_c = dx[C] ? C'(-dx) : C'(dx);
  assign ady_c = dy[C] ? C'(-dy) : C'(dy);

  assign sqx  = s1_adx * s1_adx;
  assign sqy  = s1_ady * s1_ady;
  assign mx_c = s1_w * s1_ady;
  assign my_c = s1_w * s1_adx;

  assign tsq_x = s2_mx * s2_mx;
  assign tsq_y = s2_my * s2_my;
  assign tx    = W'(tsq_x) << SH;
  assign ty    = W'(tsq_y) << SH;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      dn_valid <= 1'b0;
    end else begin
      if (rdy1) s1_valid <= up_valid;
      if (rdy2) s2_valid <= s1_valid;
      if (rdy3) dn_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && up_valid) begin
      s1_adx  <= adx_c;
      s1_ady  <= ady_c;
      s1_w    <= w;
      s1_side <= {dy[C], dx[C], side_in};
    end
    if (rdy2 && s1_valid) begin
      s2_lsq  <= LW'(sqx) + LW'(sqy);
      s2_mx   <= mx_c;
      s2_my   <= my_c;
      s2_side <= s1_side;
    end
    if (rdy3 && s2_valid) begin
      dn_res_x <= $signed(tx - W'(s2_lsq));
      dn_res_y <= $signed(ty - W'(s2_lsq));
      dn_p     <= -$signed(PW'(s2_lsq));
      dn_lsq   <= s2_lsq;
      dn_side  <= {(s2_lsq == '0), s2_side};
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/wlqe_cell.sv
// ----------------------------------------------------------------------------
// wlqe_cell: one bit cell of the offset chain
// Decides one result bit for both offset lanes by a shifted trial subtract.
// ----------------------------------------------------------------------------
`default_nettype none

module wlqe_cell import wlqe_pkg::*; #(
  parameter int W   = 86,
  parameter int PW  = 59,
  parameter int LW  = 31,
  parameter int SW  = 172,
  parameter int BIT = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  logic signed [W-1:0]  up_res_x,
  input  logic signed [W-1:0]  up_res_y,
  input  logic signed [PW-1:0] up_p_x,
  input  logic signed [PW-1:0] up_p_y,
  input  logic [RBITS-1:0]     up_r_x,
  input  logic [RBITS-1:0]     up_r_y,
  input  logic [LW-1:0]        up_lsq,
  input  logic [SW-1:0]        up_side,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output logic signed [W-1:0]  dn_res_x,
  output logic signed [W-1:0]  dn_res_y,
  output logic signed [PW-1:0] dn_p_x,
  output logic signed [PW-1:0] dn_p_y,
  output logic [RBITS-1:0]     dn_r_x,
  output logic [RBITS-1:0]     dn_r_y,
  output logic [LW-1:0]        dn_lsq,
  output logic [SW-1:0]        dn_side
);

  logic signed [PW-1:0] lsq_s, lsq_b, sum_x, sum_y;
  logic signed [W-1:0]  trial_x, trial_y;
  logic                 acc_x, acc_y, take;

  assign up_ready = !dn_valid || dn_ready;
  assign take     = up_valid && up_ready;

  // Residual holds T - (2r-1)^2*lsq; p holds (2r-1)*lsq.
  assign lsq_s   = $signed(PW'(up_lsq));
  assign lsq_b   = lsq_s <<< BIT;
  assign sum_x   = up_p_x + lsq_b;
  assign sum_y   = up_p_y + lsq_b;
  assign trial_x = up_res_x - (W'(sum_x) <<< (BIT + 2));
  assign trial_y = up_res_y - (W'(sum_y) <<< (BIT + 2));
  assign acc_x   = !trial_x[W-1];
  assign acc_y   = !trial_y[W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      dn_res_x <= acc_x ? trial_x : up_res_x;
      dn_res_y <= acc_y ? trial_y : up_res_y;
      dn_p_x   <= acc_x ? sum_x + lsq_b : up_p_x;
      dn_p_y   <= acc_y ? sum_y + lsq_b : up_p_y;
      dn_r_x   <= up_r_x | (RBITS'(acc_x) << BIT);
      dn_r_y   <= up_r_y | (RBITS'(acc_y) << BIT);
      dn_lsq   <= up_lsq;
      dn_side  <= up_side;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/wlqe_emit.sv
// ----------------------------------------------------------------------------
// wlqe_emit: vertex sequencer
// Holds one segment; sends its six or ten vertices one a cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module wlqe_emit import wlqe_pkg::*; #(
  parameter int C = 15,
  parameter int F = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        up_valid,
  output logic                        up_ready,
  input  logic signed [C-1:0]         sx,
  input  logic signed [C-1:0]         sy,
  input  logic signed [C-1:0]         ex,
  input  logic signed [C-1:0]         ey,
  input  logic signed [RBITS:0]       wx,
  input  logic signed [RBITS:0]       wy,
  input  logic [COLOR_BITS-1:0]       c1,
  input  logic [COLOR_BITS-1:0]       c2,
  input  logic [COLOR_BITS-1:0]       cs,
  input  logic                        stroke,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [VERT_BITS-1:0] vert_x,
  output logic signed [VERT_BITS-1:0] vert_y,
  output logic [COLOR_BITS-1:0]       color_rgba,
  output logic                        is_outline,
  output logic                        last_vertex
);

  localparam int VW = ((C + F > RBITS + 1) ? C + F : RBITS + 1) + 2;
  localparam logic signed [VW-1:0] VMAX = VW'(2 ** (VERT_BITS - 1) - 1);
  localparam logic signed [VW-1:0] VMIN = -VMAX - VW'(1);

  logic                    held;
  logic [CNT_BITS-1:0]     cnt;
  logic signed [C-1:0]     h_sx, h_sy, h_ex, h_ey;
  logic signed [RBITS:0]   h_wx, h_wy;
  logic [COLOR_BITS-1:0]   h_c1, h_c2, h_cs, col;
  logic                    h_stroke;

  vsel_t                   sel;
  logic                    out_free, advance, final_k, load;
  logic signed [VW-1:0]    bx, by, ox, oy, vx, vy;

  function automatic logic signed [VERT_BITS-1:0] sat(input logic signed [VW-1:0] v);
    logic signed [VW-1:0] t;
    t = (v > VMAX) ? VMAX : ((v < VMIN) ? VMIN : v);
    return t[VERT_BITS-1:0];
  endfunction

  assign out_free = !out_valid || !out_stall;
  assign advance  = held && out_free;
  assign final_k  = (cnt == VTX_OUTLINE_LAST) || (cnt == VTX_STRIP_LAST && !h_stroke);
  assign up_ready = !held || (advance && final_k);
  assign load     = up_valid && up_ready;

  always_comb begin
    sel = vertex_sel(cnt);
    bx  = sel.use_end ? VW'(h_ex) <<< F : VW'(h_sx) <<< F;
    by  = sel.use_end ? VW'(h_ey) <<< F : VW'(h_sy) <<< F;
    case (sel.ofs)
      OFS_MINUS: begin
        ox = -VW'(h_wx);
        oy = VW'(h_wy);
      end
      OFS_PLUS: begin
        ox = VW'(h_wx);
        oy = -VW'(h_wy);
      end
      default: begin
        ox = '0;
        oy = '0;
      end
    endcase
    vx = bx + ox;
    vy = by + oy;
    case (sel.col)
      COL_END:  col = h_c2;
      COL_LINE: col = h_cs;
      default:  col = h_c1;
    endcase
    if (sel.fade) col = col & ALPHA_CLEAR;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held      <= 1'b0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) out_valid <= 1'b1;
      else if (out_free) out_valid <= 1'b0;
      if (load) held <= 1'b1;
      else if (advance && final_k) held <= 1'b0;
      if (load) cnt <= '0;
      else if (advance) cnt <= final_k ? '0 : cnt + CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      h_sx     <= sx;
      h_sy     <= sy;
      h_ex     <= ex;
      h_ey     <= ey;
      h_wx     <= wx;
      h_wy     <= wy;
      h_c1     <= c1;
      h_c2     <= c2;
      h_cs     <= cs;
      h_stroke <= stroke;
    end
    if (advance) begin
      vert_x      <= sat(vx);
      vert_y      <= sat(vy);
      color_rgba  <= col;
      is_outline  <= sel.outline;
      last_vertex <= final_k;
    end
  end

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for wide_line_quad_expander_top
// Sends line segments through the input channel and checks every vertex that
// comes back against an in-bench vertex generator.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench import wlqe_pkg::*;;

  localparam int FRAC        = 8;
  localparam int HOLD_CYCLES = 160;
  localparam int WATCH_LIMIT = 3000;
  localparam int RAND_PER_PHASE = 32;

  // One input request: a segment with its width, colors and outline flag.
  typedef struct {
    int          sx, sy, ex, ey;
    int          w;
    bit [31:0]   c1, c2, cs;
    bit          en;
  } segment_t;

  // A row of the directed table. When known is set, the half-width offset
  // is taken from the row instead of being computed.
  typedef struct {
    segment_t seg;
    bit       known;
    int       kwx, kwy;
  } seg_row_t;

  typedef struct {
    logic signed [VERT_BITS-1:0] x, y;
    logic [COLOR_BITS-1:0]       c;
    logic                        o, l;
  } vertex_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic signed [14:0]    start_x = '0, start_y = '0, end_x = '0, end_y = '0;
  logic [WIDTH_BITS-1:0] line_width = '0;
  logic [COLOR_BITS-1:0] start_color = '0, end_color = '0, outline_color = '0;
  logic                  outline_enable = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic signed [VERT_BITS-1:0] vert_x, vert_y;
  logic [COLOR_BITS-1:0] color_rgba;
  logic                  is_outline, last_vertex;

  wide_line_quad_expander_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
    .line_width(line_width), .start_color(start_color), .end_color(end_color),
    .outline_color(outline_color), .outline_enable(outline_enable),
    .out_valid(out_valid), .out_stall(out_stall),
    .vert_x(vert_x), .vert_y(vert_y), .color_rgba(color_rgba),
    .is_outline(is_outline), .last_vertex(last_vertex)
  );

  // 12 ns clock.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  vertex_t pending_verts[$];
  int      errors = 0;
  int      segs_sent = 0;
  int      verts_seen = 0;
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;
  bit      hold_req = 1'b0;
  int      hold_left = 0;
  int      quiet_cycles = 0;

  task automatic report(input string what, input longint got, input longint want);
    $display("vertex %0d: %s got %0h expected %0h", verts_seen, what, got, want);
    errors++;
  endtask

  function automatic logic signed [VERT_BITS-1:0] clamp_vert(input longint v);
    if (v > 64'sd8388607) v = 64'sd8388607;
    if (v < -64'sd8388608) v = -64'sd8388608;
    return v[VERT_BITS-1:0];
  endfunction

  // Largest r with ((2r-1)*32)^2 * len^2 <= (2*num)^2, i.e. num/(32*len)
  // rounded to nearest, found one bit at a time from the top.
  function automatic longint rounded_offset(input longint num, input longint lsq);
    bit [127:0] rhs, a, lhs;
    longint     r, cand;
    rhs = 128'(num) * 2 * 128'(num) * 2;
    r = 0;
    for (int b = 24; b >= 0; b--) begin
      cand = r | (64'sd1 << b);
      a = 128'((2 * cand - 1) * 32);
      lhs = a * a * 128'(lsq);
      if (lhs <= rhs) r = cand;
    end
    return r;
  endfunction

  function automatic void half_width_offset(input segment_t s, output longint wx,
                                            output longint wy);
    longint dx, dy, adx, ady, lsq;
    dx = s.ex - s.sx;
    dy = s.ey - s.sy;
    adx = dx < 0 ? -dx : dx;
    ady = dy < 0 ? -dy : dy;
    lsq = adx * adx + ady * ady;
    if (lsq == 0) begin
      wx = 0;
      wy = ((longint'(s.w) << FRAC) + ZERO_ROUND) >>> ZERO_SHIFT;
    end else begin
      wx = rounded_offset(longint'(s.w) * ady * (64'sd1 << FRAC), lsq);
      wy = rounded_offset(longint'(s.w) * adx * (64'sd1 << FRAC), lsq);
      if (dy < 0) wx = -wx;
      if (dx < 0) wy = -wy;
    end
  endfunction

  function automatic void push_vertex(input longint x, input longint y,
                                      input bit [31:0] c, input bit o, input bit l);
    vertex_t v;
    v.x = clamp_vert(x);
    v.y = clamp_vert(y);
    v.c = c;
    v.o = o;
    v.l = l;
    pending_verts = {pending_verts, v};
  endfunction

  // Strip S-o, E-o, S, E, S+o, E+o, then the outline loop if enabled.
  function automatic void queue_segment_verts(input segment_t s, input longint wx,
                                              input longint wy);
    longint fsx, fsy, fex, fey;
    fsx = longint'(s.sx) << FRAC;
    fsy = longint'(s.sy) << FRAC;
    fex = longint'(s.ex) << FRAC;
    fey = longint'(s.ey) << FRAC;
    push_vertex(fsx - wx, fsy + wy, s.c1 & ALPHA_CLEAR, 1'b0, 1'b0);
    push_vertex(fex - wx, fey + wy, s.c2 & ALPHA_CLEAR, 1'b0, 1'b0);
    push_vertex(fsx, fsy, s.c1, 1'b0, 1'b0);
    push_vertex(fex, fey, s.c2, 1'b0, 1'b0);
    push_vertex(fsx + wx, fsy - wy, s.c1 & ALPHA_CLEAR, 1'b0, 1'b0);
    push_vertex(fex + wx, fey - wy, s.c2 & ALPHA_CLEAR, 1'b0, !s.en);
    if (s.en) begin
      push_vertex(fsx - wx, fsy + wy, s.cs, 1'b1, 1'b0);
      push_vertex(fex - wx, fey + wy, s.cs, 1'b1, 1'b0);
      push_vertex(fex + wx, fey - wy, s.cs, 1'b1, 1'b0);
      push_vertex(fsx + wx, fsy - wy, s.cs, 1'b1, 1'b1);
    end
  endfunction

  // Offers one segment starting at a falling edge and returns at the falling
  // edge after it was taken. Valid stays high afterwards unless the next call
  // idles first, so back-to-back requests never drop valid.
  task automatic send_segment(input segment_t s, input bit known, input longint kwx,
                              input longint kwy);
    longint wx, wy;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    start_x = s.sx[14:0];
    start_y = s.sy[14:0];
    end_x = s.ex[14:0];
    end_y = s.ey[14:0];
    line_width = s.w[11:0];
    start_color = s.c1;
    end_color = s.c2;
    outline_color = s.cs;
    outline_enable = s.en;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    if (known) begin
      wx = kwx;
      wy = kwy;
    end else begin
      half_width_offset(s, wx, wy);
    end
    queue_segment_verts(s, wx, wy);
    segs_sent++;
    @(negedge clk);
  endtask

  function automatic segment_t random_segment();
    segment_t s;
    int       shape;
    shape = $urandom_range(9);
    s.sx = $urandom_range(32767) - 16384;
    s.sy = $urandom_range(32767) - 16384;
    if (shape < 3) begin
      // Short segments give the finely rounded offsets.
      s.ex = s.sx + $urandom_range(16) - 8;
      s.ey = s.sy + $urandom_range(16) - 8;
      if (s.ex > 16383 || s.ex < -16384) s.ex = s.sx;
      if (s.ey > 16383 || s.ey < -16384) s.ey = s.sy;
    end else begin
      s.ex = $urandom_range(32767) - 16384;
      s.ey = $urandom_range(32767) - 16384;
    end
    if (shape == 3) begin
      s.ex = s.sx;
      s.ey = s.sy;
    end
    if (shape == 4) s.ey = s.sy;
    if (shape == 5) s.ex = s.sx;
    s.w = $urandom_range(4095);
    s.c1 = $urandom;
    s.c2 = $urandom;
    s.cs = $urandom;
    s.en = $urandom_range(1);
    return s;
  endfunction

  // Directed table. Offsets are typed in where they can be read off directly:
  // zero-length segments, zero width and axis-aligned segments.
  seg_row_t dir_rows [13];

  initial begin
    dir_rows = '{
      // Zero-length segment at the origin, one pixel wide.
      '{'{0, 0, 0, 0, 16, 32'h11223344, 32'h55667788, 32'h99AABBCC, 1'b0},
        1'b1, 0, 128},
      // Zero-length at a corner with the widest line and the outline.
      '{'{16383, -16384, 16383, -16384, 4095, 32'hFFFFFFFF, 32'h00000000,
          32'hFFFFFFFF, 1'b1}, 1'b1, 0, 32760},
      // Zero width collapses the strip onto the segment.
      '{'{-5, 7, 100, -3, 0, 32'hA5A5A5A5, 32'h5A5A5A5A, 32'h0F0F0F0F, 1'b1},
        1'b1, 0, 0},
      '{'{0, 0, 10, 0, 32, 32'h000000FF, 32'hFF000000, 32'h12345678, 1'b0},
        1'b1, 0, 256},
      '{'{3, 5, 3, -5, 32, 32'hDEADBEEF, 32'hCAFEF00D, 32'h80000001, 1'b1},
        1'b1, -256, 0},
      '{'{0, 0, 1, 0, 4095, 32'h01020304, 32'h05060708, 32'h090A0B0C, 1'b0},
        1'b1, 0, 32760},
      '{'{10, 0, 0, 0, 32, 32'h7F7F7F7F, 32'h80808080, 32'h00FF00FF, 1'b1},
        1'b1, 0, -256},
      '{'{-16384, 16383, -16384, -16384, 4095, 32'h00000000, 32'h00000000,
          32'h00000000, 1'b0}, 1'b1, -32760, 0},
      // Longest diagonals in both directions.
      '{'{-16384, -16384, 16383, 16383, 4095, 32'hFFFFFFFF, 32'hFFFFFFFF,
          32'h00000000, 1'b1}, 1'b0, 0, 0},
      '{'{16383, -16384, -16384, 16383, 1, 32'h13579BDF, 32'h2468ACE0,
          32'hFEDCBA98, 1'b0}, 1'b0, 0, 0},
      '{'{0, 0, 3, 4, 80, 32'hAABBCCDD, 32'h11111111, 32'h22222222, 1'b1},
        1'b0, 0, 0},
      '{'{0, 0, 1, 1, 3, 32'h00FF00FF, 32'hFF00FF00, 32'hC3C3C3C3, 1'b1},
        1'b0, 0, 0},
      '{'{7, 7, 8, 9, 2, 32'hFFFFFF00, 32'h000000FF, 32'h3C3C3C3C, 1'b0},
        1'b0, 0, 0}
    };
  end

  // Receiver: random stalls at the falling edge, plus a long hold-off on
  // request, counted here so the sender keeps offering while it runs.
  always @(negedge clk) begin
    if (hold_req && hold_left == 0) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else begin
      out_stall = ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Vertex checker: every accepted vertex is compared with the oldest one
  // still expected, field by field.
  always @(posedge clk) begin
    vertex_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_verts.size() == 0) begin
        report("unexpected vertex x", vert_x, 0);
      end else begin
        want = pending_verts.pop_front();
        if (vert_x !== want.x) report("vert_x", vert_x, want.x);
        if (vert_y !== want.y) report("vert_y", vert_y, want.y);
        if (color_rgba !== want.c) report("color_rgba", color_rgba, want.c);
        if (is_outline !== want.o) report("is_outline", is_outline, want.o);
        if (last_vertex !== want.l) report("last_vertex", last_vertex, want.l);
      end
      verts_seen++;
    end
  end

  // Watchdog: a long run of cycles with no request moving on either channel
  // means the block has hung.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCH_LIMIT) begin
      $display("wide_line_quad_expander_top: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    segment_t s;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part, with the sender slow to idle and the receiver busy.
    send_idle_pct = 9;
    recv_idle_pct = 76;
    foreach (dir_rows[i])
      send_segment(dir_rows[i].seg, dir_rows[i].known, dir_rows[i].kwx,
                   dir_rows[i].kwy);

    // Random part in three phases of idling. Between phases the sender waits
    // for the block to drain completely.
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 9 : (phase == 1) ? 76 : 0;
      recv_idle_pct = (phase == 0) ? 76 : (phase == 1) ? 9 : 0;
      if (phase > 0) begin
        in_valid = 1'b0;
        wait (pending_verts.size() == 0);
        @(negedge clk);
      end
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        // Mid-way through the last phase the receiver holds off long enough
        // for the pipeline to fill and push back on the input.
        if (phase == 2 && n == 4) hold_req = 1'b1;
        s = random_segment();
        send_segment(s, 1'b0, 0, 0);
      end
    end
    in_valid = 1'b0;

    wait (pending_verts.size() == 0);
    repeat (40) @(posedge clk);
    $display("Sent %0d segments (directed table plus random), checked %0d vertices,",
             segs_sent, verts_seen);
    $display("under three stall patterns and one long output hold-off.");
    if (errors == 0 && pending_verts.size() == 0) begin
      $display("wide_line_quad_expander_top: match");
    end else begin
      $display("wide_line_quad_expander_top: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
